FILE: design/rsnh_pkg.sv
// rsnh_pkg: shared constants for the nearest-hit beam caster.
// Field offsets of the stream words, unit widths and command codes.
// No dependencies.
`timescale 1ns / 1ps
package rsnh_pkg;

  // command carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_W      = 11;

  // input word field offsets
  localparam int SEG_LSB = 0;
  localparam int SEG_W   = 10;
  localparam int AX_LSB  = 10;
  localparam int AY_LSB  = 42;
  localparam int BX_LSB  = 74;
  localparam int BY_LSB  = 106;
  localparam int FLD_W   = 32;
  localparam int SR_LSB  = 138;
  localparam int RANGE_W = 31;
  localparam int COS_LSB = 169;
  localparam int SIN_LSB = 185;
  localparam int MIR_W   = 16;

  // shared multiplier
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // fraction of the divider: q = floor(2^32 * num / den), up to 2^32
  localparam int FRAC_BITS = 32;
  localparam int QW        = FRAC_BITS + 1;
  localparam int MIR_SHIFT = 14;

  localparam logic [RANGE_W-1:0] RANGE_MAX = {RANGE_W{1'b1}};

endpackage

FILE: design/rsnh_mul.sv
// rsnh_mul: shared signed multiplier with registered product.
// Depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_mul (
  input  logic                                clk,
  input  logic signed [rsnh_pkg::MUL_W-1:0]   a,
  input  logic signed [rsnh_pkg::MUL_W-1:0]   b,
  output logic signed [rsnh_pkg::PROD_W-1:0]  p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

FILE: design/rsnh_sqrt.sv
// rsnh_sqrt: digit-by-digit integer square root, one result bit a cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
module rsnh_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            done_r,
  output logic [RW-1:0]   root_r
);

  localparam int CNTW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_r;
  logic [RW+1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [RW+1:0]   rem2;
  logic [RW+1:0]   trial;

  assign rem2  = {rem_r[RW-1:0], rad_r[2*RW-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[2*RW-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem_r  <= rem2 - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem2;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        if (cnt_r == CNTW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/rsnh_div.sv
// rsnh_div: restoring fraction divider, q = floor(2^32 * num / den), num <= den.
// One quotient bit a cycle. Depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_div #(
  parameter int NW = 67
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NW-1:0]              num,
  input  logic [NW-1:0]              den,
  output logic                       done_r,
  output logic [rsnh_pkg::QW-1:0]    q_r
);

  localparam int CNTW = $clog2(rsnh_pkg::QW + 1);

  logic [NW-1:0]   num_r;
  logic [NW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic [NW-1:0]   n2;

  // first step compares without shifting (integer bit of q)
  assign n2 = (cnt_r == '0) ? num_r : {num_r[NW-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= num;
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        if (n2 >= den_r) begin
          num_r <= n2 - den_r;
          q_r   <= {q_r[rsnh_pkg::QW-2:0], 1'b1};
        end else begin
          num_r <= n2;
          q_r   <= {q_r[rsnh_pkg::QW-2:0], 1'b0};
        end
        if (cnt_r == CNTW'(rsnh_pkg::QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

endmodule

FILE: design/ray_segment_nearest_hit.sv
// ray_segment_nearest_hit: top level of the nearest-hit beam caster.
// Uses rsnh_pkg, rsnh_mul, rsnh_sqrt and rsnh_div.
`timescale 1ns / 1ps
// Beam caster over a table of wall segments. A word with in_tuser = 0 stores
// one segment at seg_index (indexes at or beyond MAX_SEGMENTS are dropped) and
// returns an all-zero result. A word with in_tuser = 1 casts a beam from A to B
// against table entries 0 .. min(active_segments, MAX_SEGMENTS)-1 and returns
// the nearest hit range below start_range, the range scaled by the mirror
// cosine/sine (Q1.14, floored, saturated) and a hit flag. Every product goes
// through one shared 34x34 multiplier, the beam length through a
// one-bit-per-cycle square root and the hit parameter through a
// one-bit-per-cycle divider. A cast first computes the beam length, then
// visits each segment; only one that passes the bounds test goes through the
// divider (a parallel or missed one is skipped before it), and a hit adds the
// mirror products at the end.
// in_tready is low from the accepted word until its result is loaded into the
// output register; the result then waits there while the next word is taken.
// Table entries never written read as garbage; cast only over written ones.
module ray_segment_nearest_hit #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rsnh_pkg::CFG_W-1:0]          cfg_wdata,   // active_segments
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // seg_index, point_a_x, point_a_y, point_b_x, point_b_y, start_range,
  // mirror_cos, mirror_sin, zero pad
  input  logic [rsnh_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,    // cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // range, hit_x, hit_y, zero pad
  output logic [rsnh_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tuser    // hit
);

  localparam int DW   = COORD_BITS + 1;       // coordinate difference
  localparam int AW   = 2 * DW + 1;           // products and their differences
  localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int EW   = 4 * COORD_BITS;
  localparam int MXW  = rsnh_pkg::MUL_W;
  localparam int PW   = rsnh_pkg::PROD_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ0  = 5'd1;
  localparam logic [4:0] S_SQ1  = 5'd2;
  localparam logic [4:0] S_SQ2  = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_NEXT = 5'd5;
  localparam logic [4:0] S_RD   = 5'd6;
  localparam logic [4:0] S_M0   = 5'd7;
  localparam logic [4:0] S_M1   = 5'd8;
  localparam logic [4:0] S_M2   = 5'd9;
  localparam logic [4:0] S_M3   = 5'd10;
  localparam logic [4:0] S_M4   = 5'd11;
  localparam logic [4:0] S_M5   = 5'd12;
  localparam logic [4:0] S_M6   = 5'd13;
  localparam logic [4:0] S_CHK  = 5'd14;
  localparam logic [4:0] S_CMP  = 5'd15;
  localparam logic [4:0] S_DIV  = 5'd16;
  localparam logic [4:0] S_QL   = 5'd17;
  localparam logic [4:0] S_RNG  = 5'd18;
  localparam logic [4:0] S_MIR0 = 5'd19;
  localparam logic [4:0] S_MIR1 = 5'd20;
  localparam logic [4:0] S_MIR2 = 5'd21;
  localparam logic [4:0] S_DONE = 5'd22;

  function automatic logic signed [DW-1:0] sxc(input logic [COORD_BITS-1:0] v);
    sxc = {v[COORD_BITS-1], v};
  endfunction

  function automatic logic signed [MXW-1:0] extd(input logic signed [DW-1:0] v);
    extd = {{(MXW-DW){v[DW-1]}}, v};
  endfunction

  // floor(p / 2^14), saturated to signed 32 bit
  function automatic logic [31:0] mir_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p >>> rsnh_pkg::MIR_SHIFT;
    if (s[PW-1:31] != {(PW-31){s[PW-1]}}) begin
      mir_sat = s[PW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      mir_sat = s[31:0];
    end
  endfunction

  logic [4:0]   state_r, state_nxt;
  logic [rsnh_pkg::CFG_W-1:0] active_r;

  // segment table: {b.y, b.x, a.y, a.x}
  logic [EW-1:0] seg_mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_data_r;

  logic signed [DW-1:0] ax_r, ay_r, dx_r, dy_r;
  logic signed [DW-1:0] ex_r, ey_r, fx_r, fy_r;
  logic signed [AW-1:0] acc_r, den_r, na_r, nb_r;
  logic [DW-1:0]        len_r;
  logic [CW-1:0]        idx_r, n_r;
  logic [rsnh_pkg::RANGE_W-1:0] min_r;
  logic                 hit_r;
  logic [31:0]          hx_r, hy_r;
  logic signed [rsnh_pkg::MIR_W-1:0] cos_r, sin_r;

  logic                 out_valid_r;
  logic [rsnh_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                 out_hit_r;

  logic                 in_fire;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [31:0]          seg32, act32;

  logic signed [MXW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [AW-1:0]  prod_lo, acc_sum, acc_dif;

  logic sq_start, sq_done;
  logic [DW-1:0] sq_root;
  logic dv_start, dv_done;
  logic [rsnh_pkg::QW-1:0] dv_q;

  logic [PW-1-rsnh_pkg::FRAC_BITS:0] r_wide;
  logic [rsnh_pkg::RANGE_W-1:0]      r_sat;
  logic                              out_free;
  logic signed [DW-1:0] sx_w, sy_w;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign seg32   = 32'(in_tdata[rsnh_pkg::SEG_LSB +: rsnh_pkg::SEG_W]);
  assign wr_addr = IW'(seg32);
  assign wr_en   = in_fire && (in_tuser == rsnh_pkg::CMD_WRITE) &&
                   (seg32 < 32'(MAX_SEGMENTS));
  assign act32   = 32'(active_r);

  assign prod_lo = mul_p[AW-1:0];
  assign acc_sum = acc_r + prod_lo;
  assign acc_dif = acc_r - prod_lo;

  assign r_wide = mul_p[PW-1:rsnh_pkg::FRAC_BITS];
  assign r_sat  = (r_wide > (PW-rsnh_pkg::FRAC_BITS)'(rsnh_pkg::RANGE_MAX)) ?
                  rsnh_pkg::RANGE_MAX : r_wide[rsnh_pkg::RANGE_W-1:0];

  assign sx_w = sxc(rd_data_r[COORD_BITS-1:0]);
  assign sy_w = sxc(rd_data_r[2*COORD_BITS-1:COORD_BITS]);

  // ---- shared units
  rsnh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign sq_start = (state_r == S_SQ2);

  rsnh_sqrt #(.RW(DW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc_sum[2*DW-1:0]),
    .done_r   (sq_done),
    .root_r   (sq_root)
  );

  assign dv_start = (state_r == S_CMP) && !na_r[AW-1] && !nb_r[AW-1] &&
                    (na_r <= den_r) && (nb_r <= den_r);

  rsnh_div #(.NW(AW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dv_start),
    .num    (na_r),
    .den    (den_r),
    .done_r (dv_done),
    .q_r    (dv_q)
  );

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ0:  begin mul_a = extd(dx_r); mul_b = extd(dx_r); end
      S_SQ1:  begin mul_a = extd(dy_r); mul_b = extd(dy_r); end
      S_M0:   begin mul_a = extd(ey_r); mul_b = extd(dx_r); end
      S_M1:   begin mul_a = extd(ex_r); mul_b = extd(dy_r); end
      S_M2:   begin mul_a = extd(ex_r); mul_b = extd(fy_r); end
      S_M3:   begin mul_a = extd(ey_r); mul_b = extd(fx_r); end
      S_M4:   begin mul_a = extd(dx_r); mul_b = extd(fy_r); end
      S_M5:   begin mul_a = extd(dy_r); mul_b = extd(fx_r); end
      S_QL:   begin
        mul_a = MXW'(dv_q);
        mul_b = MXW'(len_r);
      end
      S_MIR0: begin
        mul_a = MXW'(min_r);
        mul_b = {{(MXW-rsnh_pkg::MIR_W){cos_r[rsnh_pkg::MIR_W-1]}}, cos_r};
      end
      S_MIR1: begin
        mul_a = MXW'(min_r);
        mul_b = {{(MXW-rsnh_pkg::MIR_W){sin_r[rsnh_pkg::MIR_W-1]}}, sin_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tuser == rsnh_pkg::CMD_CAST) ? S_SQ0 : S_DONE;
        end
      end
      S_SQ0:  state_nxt = S_SQ1;
      S_SQ1:  state_nxt = S_SQ2;
      S_SQ2:  state_nxt = S_SQW;
      S_SQW:  if (sq_done) begin state_nxt = S_NEXT; end
      S_NEXT: begin
        if (idx_r >= n_r) begin
          state_nxt = hit_r ? S_MIR0 : S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_M6;
      S_M6:   state_nxt = S_CHK;
      S_CHK:  state_nxt = (den_r == '0) ? S_NEXT : S_CMP;
      S_CMP:  state_nxt = dv_start ? S_DIV : S_NEXT;
      S_DIV:  if (dv_done) begin state_nxt = S_QL; end
      S_QL:   state_nxt = S_RNG;
      S_RNG:  state_nxt = S_NEXT;
      S_MIR0: state_nxt = S_MIR1;
      S_MIR1: state_nxt = S_MIR2;
      S_MIR2: state_nxt = S_DONE;
      S_DONE: if (out_free) begin state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_mem[wr_addr] <= {in_tdata[rsnh_pkg::BY_LSB +: COORD_BITS],
                           in_tdata[rsnh_pkg::BX_LSB +: COORD_BITS],
                           in_tdata[rsnh_pkg::AY_LSB +: COORD_BITS],
                           in_tdata[rsnh_pkg::AX_LSB +: COORD_BITS]};
    end
    rd_data_r <= seg_mem[idx_r[IW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        active_r <= cfg_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        hit_r <= 1'b0;
        hx_r  <= '0;
        hy_r  <= '0;
        idx_r <= '0;
        min_r <= (in_tuser == rsnh_pkg::CMD_CAST) ?
                 in_tdata[rsnh_pkg::SR_LSB +: rsnh_pkg::RANGE_W] : '0;
        n_r   <= (act32 > 32'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS) : CW'(act32);
        cos_r <= in_tdata[rsnh_pkg::COS_LSB +: rsnh_pkg::MIR_W];
        sin_r <= in_tdata[rsnh_pkg::SIN_LSB +: rsnh_pkg::MIR_W];
        ax_r  <= sxc(in_tdata[rsnh_pkg::AX_LSB +: COORD_BITS]);
        ay_r  <= sxc(in_tdata[rsnh_pkg::AY_LSB +: COORD_BITS]);
        dx_r  <= sxc(in_tdata[rsnh_pkg::BX_LSB +: COORD_BITS]) -
                 sxc(in_tdata[rsnh_pkg::AX_LSB +: COORD_BITS]);
        dy_r  <= sxc(in_tdata[rsnh_pkg::BY_LSB +: COORD_BITS]) -
                 sxc(in_tdata[rsnh_pkg::AY_LSB +: COORD_BITS]);
      end
      S_SQ1:  acc_r <= prod_lo;
      S_SQW:  if (sq_done) begin len_r <= sq_root; end
      S_RD: begin
        ex_r <= sxc(rd_data_r[3*COORD_BITS-1:2*COORD_BITS]) - sx_w;
        ey_r <= sxc(rd_data_r[4*COORD_BITS-1:3*COORD_BITS]) - sy_w;
        fx_r <= ax_r - sx_w;
        fy_r <= ay_r - sy_w;
      end
      S_M1:   acc_r <= prod_lo;
      S_M2:   den_r <= acc_dif;
      S_M3:   acc_r <= prod_lo;
      S_M4:   na_r  <= acc_dif;
      S_M5:   acc_r <= prod_lo;
      S_M6:   nb_r  <= acc_dif;
      S_CHK: begin
        // make den positive, carry the sign into both numerators
        if (den_r == '0) begin
          idx_r <= idx_r + 1'b1;
        end else if (den_r[AW-1]) begin
          den_r <= -den_r;
          na_r  <= -na_r;
          nb_r  <= -nb_r;
        end
      end
      S_CMP:  if (!dv_start) begin idx_r <= idx_r + 1'b1; end
      S_RNG: begin
        if (r_sat < min_r) begin
          min_r <= r_sat;
          hit_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      S_MIR1: hx_r <= mir_sat(mul_p);
      S_MIR2: hy_r <= mir_sat(mul_p);
      S_DONE: begin
        if (out_free) begin
          out_data_r <= {1'b0, hy_r, hx_r, min_r};
          out_hit_r  <= hit_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

endmodule

FILE: design/rsnh_checker.sv
// rsnh_checker: port-level assertions for ray_segment_nearest_hit, bound below.
// Depends on rsnh_pkg.
`timescale 1ns / 1ps
module rsnh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rsnh_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // a miss reports zero coordinates
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[94:31] == '0)
    else $error("nonzero coordinates without hit");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word taken while busy");

endmodule

bind ray_segment_nearest_hit rsnh_checker u_rsnh_checker (.*);
